### hw/rtl/bsrc_pkg.sv
// ----------------------------------------------------------------------------
// bsrc_pkg: shared types and codes for the banker's safety request checker
// Request/response payloads, function codes and status codes.
// ----------------------------------------------------------------------------
package bsrc_pkg;

    localparam int NUM_PROC_DEF = 8;
    localparam int NRES         = 3;
    localparam int UNIT_W       = 8;
    localparam int WORK_W       = 16;

    // function codes
    localparam logic [1:0] FN_LOAD  = 2'd0;
    localparam logic [1:0] FN_AVAIL = 2'd1;
    localparam logic [1:0] FN_REQ   = 2'd2;

    // status codes
    localparam logic [2:0] ST_GRANTED    = 3'd0;
    localparam logic [2:0] ST_OVER_CLAIM = 3'd1;
    localparam logic [2:0] ST_OVER_AVAIL = 3'd2;
    localparam logic [2:0] ST_UNSAFE     = 3'd3;
    localparam logic [2:0] ST_LOADED     = 3'd4;
    localparam logic [2:0] ST_REJECTED   = 3'd5;

    typedef logic [NRES-1:0][UNIT_W-1:0] t_units;
    typedef logic [NRES-1:0][WORK_W-1:0] t_work;

    typedef struct packed {
        t_units claim;
        t_units alloc;
    } t_row;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] process_id;
        logic [7:0] amount_r0;
        logic [7:0] amount_r1;
        logic [7:0] amount_r2;
        logic [7:0] claim_r0;
        logic [7:0] claim_r1;
        logic [7:0] claim_r2;
    } t_req;

    typedef struct packed {
        logic       granted;
        logic [2:0] status;
    } t_rsp;

endpackage

### hw/rtl/bsrc_if.sv
// ----------------------------------------------------------------------------
// bsrc_if: request and response channels
// Valid/ready channels carrying the checker's request and response payloads.
// ----------------------------------------------------------------------------
interface bsrc_req_if;
    logic          valid;
    logic          ready;
    bsrc_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsrc_rsp_if;
    logic          valid;
    logic          ready;
    bsrc_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/bankers_safety_request_checker.sv
// ----------------------------------------------------------------------------
// bankers_safety_request_checker: banker's algorithm request checker
// Keeps claim/allocation rows and an available vector; grants a request
// only if the resulting state passes the safety check.
// ----------------------------------------------------------------------------
// Usage: requests enter on i_req (valid/ready). func selects load of one
// process row, write of the available vector, or a resource request.
// Every request yields exactly one response on o_rsp (granted, status).
// Load, set-available and malformed requests pass through the response
// state to the output register. A resource request reads the process row,
// checks it against need and available, then runs the safety check: one
// row per cycle through a single compare/add unit, up to NUM_PROC passes.
// i_req.ready is high only while the sequencer is idle; one request is
// worked on at a time. The response sits in an output register; a new
// request is accepted while it waits, and the next result waits in the
// sequencer until o_rsp.ready frees the register.
// Reset (synchronous, active low) zeroes the available vector and clears
// all rows at once through per-row valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module bankers_safety_request_checker #(
    parameter int NUM_PROC = bsrc_pkg::NUM_PROC_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bsrc_req_if.sink     i_req,
    bsrc_rsp_if.source   o_rsp
);

    localparam int AW = (NUM_PROC > 1) ? $clog2(NUM_PROC) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_PROC - 1);
    localparam logic [AW-1:0] IDX_ONE  = AW'((NUM_PROC > 1) ? 1 : 0);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_SAFE  = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    // row storage
    bsrc_pkg::t_row          r_mem [NUM_PROC];
    logic [NUM_PROC-1:0]     r_vld;
    bsrc_pkg::t_row          r_rd_row;
    logic                    r_rd_vld;

    logic [1:0]              r_state;
    bsrc_pkg::t_units        r_avail;
    logic [AW-1:0]           r_pid;
    bsrc_pkg::t_units        r_amt;
    bsrc_pkg::t_units        r_claim;
    bsrc_pkg::t_units        r_talloc;
    bsrc_pkg::t_units        r_new_avail;
    bsrc_pkg::t_work         r_work;
    logic [NUM_PROC-1:0]     r_done;
    logic                    r_progress;
    logic [AW-1:0]           r_ptr;
    logic [AW-1:0]           r_eidx;
    bsrc_pkg::t_rsp          r_res;
    logic                    r_ovalid;
    bsrc_pkg::t_rsp          r_odata;

    logic                    accept;
    logic [AW-1:0]           in_pid;
    logic                    pid_ok;
    logic                    load_ok;
    bsrc_pkg::t_units        in_amt;
    bsrc_pkg::t_units        in_claim;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    bsrc_pkg::t_row          wr_row;
    bsrc_pkg::t_units        q_claim;
    bsrc_pkg::t_units        q_alloc;
    logic                    over_claim;
    logic                    over_avail;
    bsrc_pkg::t_units        e_alloc;
    logic                    fits;
    bsrc_pkg::t_work         work_nx;
    logic [NUM_PROC-1:0]     done_nx;
    logic                    last;
    logic                    prog;
    logic                    commit;
    logic [AW-1:0]           ptr_inc;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;

    assign in_pid      = AW'(i_req.data.process_id);
    assign pid_ok      = (5'(i_req.data.process_id) < 5'(NUM_PROC));
    assign in_amt      = {i_req.data.amount_r2, i_req.data.amount_r1, i_req.data.amount_r0};
    assign in_claim    = {i_req.data.claim_r2, i_req.data.claim_r1, i_req.data.claim_r0};
    assign ptr_inc     = (r_ptr == LAST_IDX) ? '0 : r_ptr + 1'b1;

    always_comb begin
        load_ok = pid_ok;
        for (int r = 0; r < bsrc_pkg::NRES; r++) begin
            if (in_amt[r] > in_claim[r]) begin
                load_ok = 1'b0;
            end
        end
    end

    // rows never loaded read as zero
    always_comb begin
        q_claim    = r_rd_vld ? r_rd_row.claim : '0;
        q_alloc    = r_rd_vld ? r_rd_row.alloc : '0;
        over_claim = 1'b0;
        over_avail = 1'b0;
        for (int r = 0; r < bsrc_pkg::NRES; r++) begin
            if (r_amt[r] > (q_claim[r] - q_alloc[r])) begin
                over_claim = 1'b1;
            end
            if (r_amt[r] > r_avail[r]) begin
                over_avail = 1'b1;
            end
        end
    end

    // safety-check step: one row per cycle, requester row uses tentative alloc
    always_comb begin
        e_alloc = (r_eidx == r_pid) ? r_talloc : q_alloc;
        fits    = !r_done[r_eidx];
        for (int r = 0; r < bsrc_pkg::NRES; r++) begin
            if (bsrc_pkg::WORK_W'(q_claim[r] - e_alloc[r]) > r_work[r]) begin
                fits = 1'b0;
            end
        end
        for (int r = 0; r < bsrc_pkg::NRES; r++) begin
            work_nx[r] = fits ? r_work[r] + bsrc_pkg::WORK_W'(e_alloc[r]) : r_work[r];
        end
        for (int i = 0; i < NUM_PROC; i++) begin
            done_nx[i] = r_done[i] | (fits && (r_eidx == AW'(i)));
        end
        last   = (r_eidx == LAST_IDX);
        prog   = r_progress | fits;
        commit = (r_state == S_SAFE) && last && (&done_nx);
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:  rd_addr = in_pid;
            S_CHECK: rd_addr = '0;
            default: rd_addr = r_ptr;
        endcase
        wr_en   = 1'b0;
        wr_addr = r_pid;
        wr_row  = '{claim: r_claim, alloc: r_talloc};
        if (accept && (i_req.data.func == bsrc_pkg::FN_LOAD) && load_ok) begin
            wr_en   = 1'b1;
            wr_addr = in_pid;
            wr_row  = '{claim: in_claim, alloc: in_amt};
        end else if (commit) begin
            wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
        r_rd_row <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vld      <= '0;
            r_rd_vld   <= 1'b0;
            r_avail    <= '0;
            r_done     <= '0;
            r_progress <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[rd_addr];
            // the response state refills the register itself
            if (o_rsp.ready && (r_state != S_RESP)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_req.data.func)
                            bsrc_pkg::FN_LOAD: begin
                                if (load_ok) begin
                                    r_vld[in_pid] <= 1'b1;
                                end
                                r_state <= S_RESP;
                            end
                            bsrc_pkg::FN_AVAIL: begin
                                r_avail <= in_amt;
                                r_state <= S_RESP;
                            end
                            bsrc_pkg::FN_REQ: begin
                                r_state <= pid_ok ? S_CHECK : S_RESP;
                            end
                            default: begin
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_CHECK: begin
                    r_done     <= '0;
                    r_progress <= 1'b0;
                    r_state    <= (over_claim || over_avail) ? S_RESP : S_SAFE;
                end
                S_SAFE: begin
                    r_done     <= done_nx;
                    r_progress <= last ? 1'b0 : prog;
                    if (commit) begin
                        r_avail        <= r_new_avail;
                        r_vld[r_pid]   <= 1'b1;
                        r_state        <= S_RESP;
                    end else if (last && !prog) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_pid <= in_pid;
                r_amt <= in_amt;
                unique case (i_req.data.func)
                    bsrc_pkg::FN_LOAD:
                        r_res <= '{granted: 1'b0,
                                   status: load_ok ? bsrc_pkg::ST_LOADED
                                                   : bsrc_pkg::ST_REJECTED};
                    bsrc_pkg::FN_AVAIL:
                        r_res <= '{granted: 1'b0, status: bsrc_pkg::ST_LOADED};
                    bsrc_pkg::FN_REQ:
                        r_res <= '{granted: 1'b0, status: bsrc_pkg::ST_OVER_CLAIM};
                    default:
                        r_res <= '{granted: 1'b0, status: bsrc_pkg::ST_REJECTED};
                endcase
            end
            S_CHECK: begin
                if (!over_claim) begin
                    r_res <= '{granted: 1'b0, status: bsrc_pkg::ST_OVER_AVAIL};
                end
                for (int r = 0; r < bsrc_pkg::NRES; r++) begin
                    r_new_avail[r] <= r_avail[r] - r_amt[r];
                    r_work[r]      <= bsrc_pkg::WORK_W'(r_avail[r] - r_amt[r]);
                    r_talloc[r]    <= q_alloc[r] + r_amt[r];
                end
                r_claim <= q_claim;
                r_ptr   <= IDX_ONE;
                r_eidx  <= '0;
            end
            S_SAFE: begin
                r_work <= work_nx;
                r_ptr  <= ptr_inc;
                r_eidx <= r_ptr;
                if (commit) begin
                    r_res <= '{granted: 1'b1, status: bsrc_pkg::ST_GRANTED};
                end else if (last && !prog) begin
                    r_res <= '{granted: 1'b0, status: bsrc_pkg::ST_UNSAFE};
                end
            end
            S_RESP: begin
                if (!r_ovalid || o_rsp.ready) begin
                    r_odata <= r_res;
                end
            end
            default: ;
        endcase
    end

    // a response is only launched from the response state
    a_rsp_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(r_state) == S_RESP)
        else $error("response raised outside response state");

    a_grant_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.granted |-> o_rsp.data.status == bsrc_pkg::ST_GRANTED)
        else $error("granted with non-grant status");

    // table rows change only on a load or a committed grant
    a_write_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_IDLE && accept) || (r_state == S_SAFE && last))
        else $error("row write without load or commit");

endmodule

### tb/bankers_safety_request_checker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bankers_safety_request_checker_test: self-checking bench for the checker
// Drives row loads, available writes and resource requests over the request
// channel. A shadow copy of the claim, allocation and available tables
// predicts responses the table leaves open; all checked in order. A short
// directed table comes first, then random episodes (set available, load
// rows, mostly in-need requests) under several sender/receiver idle mixes,
// including a long receiver hold-off that backs up the request side.
// ----------------------------------------------------------------------------
module bankers_safety_request_checker_test;

    localparam int NPROC          = bsrc_pkg::NUM_PROC_DEF;
    localparam int NRES           = bsrc_pkg::NRES;
    localparam logic [1:0] FN_NONE = 2'd3;    // unused function code
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 225;

    typedef struct {
        bsrc_pkg::t_req rq;
        bit             typed;
        logic           granted;
        logic [2:0]     status;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsrc_req_if req_if ();
    bsrc_rsp_if rsp_if ();

    bankers_safety_request_checker DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow state of the checker
    logic [7:0] bank_claim [NPROC][NRES];
    logic [7:0] bank_alloc [NPROC][NRES];
    logic [7:0] bank_avail [NRES];

    bsrc_pkg::t_rsp rsp_expected_q [$];
    t_dir_row       dir_rows [$];

    int src_pct       = 0;
    int snk_pct       = 0;
    bit rsp_hold      = 1'b0;
    bit hold_go       = 1'b0;
    int items_sent    = 0;
    int bad_results   = 0;
    int idle_cycles   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        for (int p = 0; p < NPROC; p++) begin
            for (int r = 0; r < NRES; r++) begin
                bank_claim[p][r] = 8'd0;
                bank_alloc[p][r] = 8'd0;
            end
        end
        for (int r = 0; r < NRES; r++) bank_avail[r] = 8'd0;
    end

    function automatic bsrc_pkg::t_req mk(logic [1:0] func, logic [2:0] pid,
                                logic [7:0] a0, logic [7:0] a1, logic [7:0] a2,
                                logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
        bsrc_pkg::t_req rq;
        rq.func       = func;
        rq.process_id = pid;
        rq.amount_r0  = a0;
        rq.amount_r1  = a1;
        rq.amount_r2  = a2;
        rq.claim_r0   = c0;
        rq.claim_r1   = c1;
        rq.claim_r2   = c2;
        return rq;
    endfunction

    // Repeated passes over unfinished processes; unsafe once a pass finishes none.
    function automatic bit bank_is_safe();
        logic [15:0] work [NRES];
        bit          done [NPROC];
        logic [7:0]  need;
        int          finished;
        bit          progress;
        bit          fits;
        for (int r = 0; r < NRES; r++) work[r] = {8'd0, bank_avail[r]};
        for (int p = 0; p < NPROC; p++) done[p] = 1'b0;
        finished = 0;
        while (finished < NPROC) begin
            progress = 1'b0;
            for (int p = 0; p < NPROC; p++) begin
                if (!done[p]) begin
                    fits = 1'b1;
                    for (int r = 0; r < NRES; r++) begin
                        need = bank_claim[p][r] - bank_alloc[p][r];
                        if ({8'd0, need} > work[r]) fits = 1'b0;
                    end
                    if (fits) begin
                        for (int r = 0; r < NRES; r++)
                            work[r] = work[r] + {8'd0, bank_alloc[p][r]};
                        done[p]  = 1'b1;
                        finished++;
                        progress = 1'b1;
                    end
                end
            end
            if (!progress) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one request to the shadow state and returns its response.
    function automatic bsrc_pkg::t_rsp bank_apply(bsrc_pkg::t_req rq);
        bsrc_pkg::t_rsp res;
        logic [7:0]     amt [NRES];
        logic [7:0]     clm [NRES];
        logic [7:0]     need;
        int             p;
        bit             ok;
        bit             over_claim;
        bit             over_avail;
        amt[0] = rq.amount_r0;  amt[1] = rq.amount_r1;  amt[2] = rq.amount_r2;
        clm[0] = rq.claim_r0;   clm[1] = rq.claim_r1;   clm[2] = rq.claim_r2;
        p           = rq.process_id;
        res.granted = 1'b0;
        res.status  = bsrc_pkg::ST_REJECTED;
        case (rq.func)
            bsrc_pkg::FN_LOAD: begin
                ok = (p < NPROC);
                for (int r = 0; r < NRES; r++)
                    if (amt[r] > clm[r]) ok = 1'b0;
                if (ok) begin
                    for (int r = 0; r < NRES; r++) begin
                        bank_claim[p][r] = clm[r];
                        bank_alloc[p][r] = amt[r];
                    end
                    res.status = bsrc_pkg::ST_LOADED;
                end
            end
            bsrc_pkg::FN_AVAIL: begin
                for (int r = 0; r < NRES; r++) bank_avail[r] = amt[r];
                res.status = bsrc_pkg::ST_LOADED;
            end
            bsrc_pkg::FN_REQ: begin
                if (p >= NPROC) begin
                    res.status = bsrc_pkg::ST_OVER_CLAIM;
                end else begin
                    over_claim = 1'b0;
                    over_avail = 1'b0;
                    for (int r = 0; r < NRES; r++) begin
                        need = bank_claim[p][r] - bank_alloc[p][r];
                        if (amt[r] > need) over_claim = 1'b1;
                        if (amt[r] > bank_avail[r]) over_avail = 1'b1;
                    end
                    if (over_claim) begin
                        res.status = bsrc_pkg::ST_OVER_CLAIM;
                    end else if (over_avail) begin
                        res.status = bsrc_pkg::ST_OVER_AVAIL;
                    end else begin
                        // tentative grant, rolled back if unsafe
                        for (int r = 0; r < NRES; r++) begin
                            bank_avail[r]    = bank_avail[r] - amt[r];
                            bank_alloc[p][r] = bank_alloc[p][r] + amt[r];
                        end
                        if (bank_is_safe()) begin
                            res.granted = 1'b1;
                            res.status  = bsrc_pkg::ST_GRANTED;
                        end else begin
                            for (int r = 0; r < NRES; r++) begin
                                bank_avail[r]    = bank_avail[r] + amt[r];
                                bank_alloc[p][r] = bank_alloc[p][r] - amt[r];
                            end
                            res.status = bsrc_pkg::ST_UNSAFE;
                        end
                    end
                end
            end
            default: res.status = bsrc_pkg::ST_REJECTED;
        endcase
        return res;
    endfunction

    task automatic add_row(bsrc_pkg::t_req rq, bit typed, logic granted,
                           logic [2:0] status);
        t_dir_row row;
        row.rq      = rq;
        row.typed   = typed;
        row.granted = granted;
        row.status  = status;
        dir_rows.push_back(row);
    endtask

    // Offers one request, waits for acceptance, then records what it must answer.
    task automatic send_request(bsrc_pkg::t_req rq, bit typed, bsrc_pkg::t_rsp typed_rsp);
        int             gap;
        bsrc_pkg::t_rsp pred;
        gap = 0;
        while ($urandom_range(99) < src_pct) gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= rq;
        do @(posedge i_clk); while (!req_if.ready);
        pred = bank_apply(rq);
        rsp_expected_q.push_back(typed ? typed_rsp : pred);
        items_sent++;
    endtask

    // One random episode: new available vector, a few rows, then requests.
    task automatic banker_episode();
        logic [7:0]     a [NRES];
        logic [7:0]     c [NRES];
        logic [7:0]     need;
        logic [7:0]     lim;
        int             p;
        int             k;
        int             r;
        int             roll;
        bsrc_pkg::t_rsp none;
        none = '0;

        for (r = 0; r < NRES; r++) begin
            a[r] = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(30));
            c[r] = 8'($urandom);
        end
        send_request(mk(bsrc_pkg::FN_AVAIL, 3'($urandom), a[0], a[1], a[2],
                        c[0], c[1], c[2]), 1'b0, none);

        for (k = $urandom_range(8, 1); k > 0; k--) begin
            p = $urandom_range(NPROC - 1);
            for (r = 0; r < NRES; r++) begin
                c[r] = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40));
                a[r] = 8'($urandom_range(c[r]));
            end
            if ($urandom_range(11) == 0) begin
                // allocation above claim on one resource
                r = $urandom_range(NRES - 1);
                if (c[r] != 8'hFF) a[r] = 8'($urandom_range(255, c[r] + 1));
            end
            send_request(mk(bsrc_pkg::FN_LOAD, 3'(p), a[0], a[1], a[2], c[0], c[1], c[2]),
                         1'b0, none);
        end

        for (k = $urandom_range(12, 4); k > 0; k--) begin
            p    = $urandom_range(NPROC - 1);
            roll = $urandom_range(99);
            for (r = 0; r < NRES; r++) begin
                c[r] = 8'($urandom);
                if (roll < 70) begin
                    need = bank_claim[p][r] - bank_alloc[p][r];
                    lim  = need;
                    if ($urandom_range(1) && bank_avail[r] < need) lim = bank_avail[r];
                    a[r] = 8'($urandom_range(lim));
                end else if (roll < 85) begin
                    a[r] = 8'($urandom_range(20));
                end else begin
                    a[r] = 8'($urandom);
                end
            end
            send_request(mk((roll >= 95) ? FN_NONE : bsrc_pkg::FN_REQ, 3'(p),
                            a[0], a[1], a[2], c[0], c[1], c[2]), 1'b0, none);
        end
    endtask

    // response side
    always @(posedge i_clk) begin
        if (!i_rst_n) rsp_if.ready <= 1'b0;
        else          rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= snk_pct);
    end

    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    always @(posedge i_clk) begin : rsp_check
        bsrc_pkg::t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (rsp_expected_q.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t: unexpected response granted=%0d status=%0d",
                             $realtime, rsp_if.data.granted, rsp_if.data.status);
            end else begin
                want = rsp_expected_q.pop_front();
                if (want.granted !== rsp_if.data.granted ||
                    want.status !== rsp_if.data.status) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%0t: mismatch: expected granted=%0d status=%0d, %s",
                                 $realtime, want.granted, want.status,
                                 $sformatf("got granted=%0d status=%0d",
                                           rsp_if.data.granted, rsp_if.data.status));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bankers_safety_request_checker_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int             src_mix [4];
        int             snk_mix [4];
        int             target;
        bsrc_pkg::t_rsp typed_rsp;

        src_mix = '{0, 56, 0, 19};
        snk_mix = '{0, 0, 56, 19};

        // fresh state: zero request passes, any nonzero one is over claim
        add_row(mk(bsrc_pkg::FN_REQ,   3'd0, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0),
                1'b1, 1'b1, bsrc_pkg::ST_GRANTED);
        add_row(mk(bsrc_pkg::FN_REQ,   3'd3, 8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0),
                1'b1, 1'b0, bsrc_pkg::ST_OVER_CLAIM);
        add_row(mk(FN_NONE,            3'd5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                1'b1, 1'b0, bsrc_pkg::ST_REJECTED);
        add_row(mk(bsrc_pkg::FN_REQ,   3'd0, 8'd0,  8'd0,  8'd1,  8'd0,  8'd0,  8'd0),
                1'b1, 1'b0, bsrc_pkg::ST_OVER_CLAIM);
        add_row(mk(bsrc_pkg::FN_AVAIL, 3'd7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                1'b1, 1'b0, bsrc_pkg::ST_LOADED);
        add_row(mk(bsrc_pkg::FN_LOAD,  3'd7, 8'd0,  8'd0,  8'd0,  8'hFF, 8'hFF, 8'hFF),
                1'b1, 1'b0, bsrc_pkg::ST_LOADED);
        // allocation above claim leaves the row alone
        add_row(mk(bsrc_pkg::FN_LOAD,  3'd0, 8'd10, 8'd0,  8'd0,  8'd9,  8'hFF, 8'hFF),
                1'b1, 1'b0, bsrc_pkg::ST_REJECTED);
        add_row(mk(bsrc_pkg::FN_LOAD,  3'd1, 8'd0,  8'd0,  8'd1,  8'd0,  8'd0,  8'd0),
                1'b1, 1'b0, bsrc_pkg::ST_REJECTED);
        add_row(mk(bsrc_pkg::FN_LOAD,  3'd6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF),
                1'b1, 1'b0, bsrc_pkg::ST_LOADED);
        // full-size grant, then no need left
        add_row(mk(bsrc_pkg::FN_REQ,   3'd7, 8'hFF, 8'hFF, 8'hFF, 8'd0,  8'd0,  8'd0),
                1'b0, 1'b0, bsrc_pkg::ST_GRANTED);
        add_row(mk(bsrc_pkg::FN_REQ,   3'd7, 8'd0,  8'd0,  8'd1,  8'd0,  8'd0,  8'd0),
                1'b0, 1'b0, bsrc_pkg::ST_GRANTED);
        add_row(mk(bsrc_pkg::FN_LOAD,  3'd7, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0),
                1'b1, 1'b0, bsrc_pkg::ST_LOADED);
        add_row(mk(bsrc_pkg::FN_LOAD,  3'd6, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0),
                1'b1, 1'b0, bsrc_pkg::ST_LOADED);
        add_row(mk(bsrc_pkg::FN_AVAIL, 3'd0, 8'd5,  8'd5,  8'd5,  8'd0,  8'd0,  8'd0),
                1'b1, 1'b0, bsrc_pkg::ST_LOADED);
        add_row(mk(bsrc_pkg::FN_LOAD,  3'd0, 8'd0,  8'd0,  8'd0,  8'd10, 8'd10, 8'd10),
                1'b1, 1'b0, bsrc_pkg::ST_LOADED);
        add_row(mk(bsrc_pkg::FN_LOAD,  3'd1, 8'd0,  8'd0,  8'd0,  8'd10, 8'd10, 8'd10),
                1'b1, 1'b0, bsrc_pkg::ST_LOADED);
        // over claim wins over over available
        add_row(mk(bsrc_pkg::FN_REQ,   3'd0, 8'd11, 8'd11, 8'd11, 8'd0,  8'd0,  8'd0),
                1'b0, 1'b0, bsrc_pkg::ST_GRANTED);
        add_row(mk(bsrc_pkg::FN_REQ,   3'd0, 8'd6,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0),
                1'b0, 1'b0, bsrc_pkg::ST_GRANTED);
        // both rows need 10 with 5 on hand: nothing is safe, not even a zero request
        add_row(mk(bsrc_pkg::FN_REQ,   3'd0, 8'd4,  8'd4,  8'd4,  8'd0,  8'd0,  8'd0),
                1'b0, 1'b0, bsrc_pkg::ST_GRANTED);
        add_row(mk(bsrc_pkg::FN_REQ,   3'd0, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0),
                1'b0, 1'b0, bsrc_pkg::ST_GRANTED);
        add_row(mk(bsrc_pkg::FN_LOAD,  3'd1, 8'd5,  8'd5,  8'd5,  8'd10, 8'd10, 8'd10),
                1'b1, 1'b0, bsrc_pkg::ST_LOADED);
        add_row(mk(bsrc_pkg::FN_REQ,   3'd0, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0),
                1'b0, 1'b0, bsrc_pkg::ST_GRANTED);
        add_row(mk(bsrc_pkg::FN_REQ,   3'd1, 8'd5,  8'd5,  8'd5,  8'd0,  8'd0,  8'd0),
                1'b0, 1'b0, bsrc_pkg::ST_GRANTED);
        add_row(mk(bsrc_pkg::FN_REQ,   3'd0, 8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0),
                1'b0, 1'b0, bsrc_pkg::ST_GRANTED);

        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            typed_rsp.granted = dir_rows[i].granted;
            typed_rsp.status  = dir_rows[i].status;
            send_request(dir_rows[i].rq, dir_rows[i].typed, typed_rsp);
        end

        for (int ph = 0; ph < 4; ph++) begin
            src_pct = src_mix[ph];
            snk_pct <= snk_mix[ph];
            // receiver holds off while requests keep coming
            if (ph == 0) hold_go = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) banker_episode();
        end
        req_if.valid <= 1'b0;

        while (rsp_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bad_results == 0)
            $display("bankers_safety_request_checker_test: PASS");
        else
            $display("bankers_safety_request_checker_test: FAIL");
        $finish;
    end

endmodule
